/* rtl/pfgp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfgp_pkg
// Shared types, constants and the 5x7 font for the page framebuffer plotter.
// ----------------------------------------------------------------------------
package pfgp_pkg;

  // default panel geometry
  localparam int DEF_PANEL_WIDTH  = 128;
  localparam int DEF_PANEL_HEIGHT = 64;
  localparam int DEF_PAGE_COUNT   = 8;

  // width of a linear byte address before the range check (255 + 31 * 256 fits)
  localparam int LIN_W = 14;

  // glyph draw: five columns, two pages each
  localparam int          STEP_W      = 4;
  localparam int          GLYPH_STEPS = 10;
  localparam logic [39:0] SETPIX_COLS = 40'h01_00_00_00_00;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_SET   = 2'd1,
    OP_GLYPH = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_FINISH,
    ST_DONE
  } seq_state_t;

  // enables of the store ports
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

  // five font columns, column 0 in the top byte, bit 0 the top row;
  // unprintable codes come back blank like a space
  function automatic logic [39:0] font_columns(input logic [7:0] code);
    logic [39:0] cols;
    case (code)
      8'd33:   cols = 40'h00_00_5F_00_00;
      8'd34:   cols = 40'h00_07_00_07_00;
      8'd35:   cols = 40'h14_7F_14_7F_14;
      8'd36:   cols = 40'h24_2A_7F_2A_12;
      8'd37:   cols = 40'h23_13_08_64_62;
      8'd38:   cols = 40'h36_49_55_22_50;
      8'd39:   cols = 40'h00_05_03_00_00;
      8'd40:   cols = 40'h00_1C_22_41_00;
      8'd41:   cols = 40'h00_41_22_1C_00;
      8'd42:   cols = 40'h14_08_3E_08_14;
      8'd43:   cols = 40'h08_08_3E_08_08;
      8'd44:   cols = 40'h00_50_30_00_00;
      8'd45:   cols = 40'h08_08_08_08_08;
      8'd46:   cols = 40'h00_60_60_00_00;
      8'd47:   cols = 40'h20_10_08_04_02;
      8'd48:   cols = 40'h3E_51_49_45_3E;
      8'd49:   cols = 40'h00_42_7F_40_00;
      8'd50:   cols = 40'h42_61_51_49_46;
      8'd51:   cols = 40'h21_41_45_4B_31;
      8'd52:   cols = 40'h18_14_12_7F_10;
      8'd53:   cols = 40'h27_45_45_45_39;
      8'd54:   cols = 40'h3C_4A_49_49_30;
      8'd55:   cols = 40'h01_71_09_05_03;
      8'd56:   cols = 40'h36_49_49_49_36;
      8'd57:   cols = 40'h06_49_49_29_1E;
      8'd58:   cols = 40'h00_36_36_00_00;
      8'd59:   cols = 40'h00_56_36_00_00;
      8'd60:   cols = 40'h08_14_22_41_00;
      8'd61:   cols = 40'h14_14_14_14_14;
      8'd62:   cols = 40'h00_41_22_14_08;
      8'd63:   cols = 40'h02_01_51_09_06;
      8'd64:   cols = 40'h32_49_79_41_3E;
      8'd65:   cols = 40'h7E_11_11_11_7E;
      8'd66:   cols = 40'h7F_49_49_49_36;
      8'd67:   cols = 40'h3E_41_41_41_22;
      8'd68:   cols = 40'h7F_41_41_22_1C;
      8'd69:   cols = 40'h7F_49_49_49_41;
      8'd70:   cols = 40'h7F_09_09_09_01;
      8'd71:   cols = 40'h3E_41_49_49_7A;
      8'd72:   cols = 40'h7F_08_08_08_7F;
      8'd73:   cols = 40'h00_41_7F_41_00;
      8'd74:   cols = 40'h20_40_41_3F_01;
      8'd75:   cols = 40'h7F_08_14_22_41;
      8'd76:   cols = 40'h7F_40_40_40_40;
      8'd77:   cols = 40'h7F_02_0C_02_7F;
      8'd78:   cols = 40'h7F_04_08_10_7F;
      8'd79:   cols = 40'h3E_41_41_41_3E;
      8'd80:   cols = 40'h7F_09_09_09_06;
      8'd81:   cols = 40'h3E_41_51_21_5E;
      8'd82:   cols = 40'h7F_09_19_29_46;
      8'd83:   cols = 40'h46_49_49_49_31;
      8'd84:   cols = 40'h01_01_7F_01_01;
      8'd85:   cols = 40'h3F_40_40_40_3F;
      8'd86:   cols = 40'h1F_20_40_20_1F;
      8'd87:   cols = 40'h3F_40_38_40_3F;
      8'd88:   cols = 40'h63_14_08_14_63;
      8'd89:   cols = 40'h07_08_70_08_07;
      8'd90:   cols = 40'h61_51_49_45_43;
      8'd91:   cols = 40'h00_7F_41_41_00;
      8'd92:   cols = 40'h02_04_08_10_20;
      8'd93:   cols = 40'h00_41_41_7F_00;
      8'd94:   cols = 40'h04_02_01_02_04;
      8'd95:   cols = 40'h40_40_40_40_40;
      8'd96:   cols = 40'h00_00_02_05_02;
      8'd97:   cols = 40'h20_54_54_54_78;
      8'd98:   cols = 40'h7F_48_44_44_38;
      8'd99:   cols = 40'h38_44_44_44_20;
      8'd100:  cols = 40'h38_44_44_48_7F;
      8'd101:  cols = 40'h38_54_54_54_18;
      8'd102:  cols = 40'h08_7E_09_01_02;
      8'd103:  cols = 40'h0C_52_52_52_3E;
      8'd104:  cols = 40'h7F_08_04_04_78;
      8'd105:  cols = 40'h00_44_7D_40_00;
      8'd106:  cols = 40'h20_40_44_3D_00;
      8'd107:  cols = 40'h7F_10_28_44_00;
      8'd108:  cols = 40'h00_41_7F_40_00;
      8'd109:  cols = 40'h7C_04_18_04_78;
      8'd110:  cols = 40'h7C_08_04_04_78;
      8'd111:  cols = 40'h38_44_44_44_38;
      8'd112:  cols = 40'h7C_14_14_14_08;
      8'd113:  cols = 40'h08_14_14_18_7C;
      8'd114:  cols = 40'h7C_08_04_04_08;
      8'd115:  cols = 40'h48_54_54_54_20;
      8'd116:  cols = 40'h04_3F_44_40_20;
      8'd117:  cols = 40'h3C_40_40_20_7C;
      8'd118:  cols = 40'h1C_20_40_20_1C;
      8'd119:  cols = 40'h3C_40_30_40_3C;
      8'd120:  cols = 40'h44_28_10_28_44;
      8'd121:  cols = 40'h0C_50_50_50_3C;
      8'd122:  cols = 40'h44_64_54_4C_44;
      8'd123:  cols = 40'h00_08_36_41_00;
      8'd124:  cols = 40'h00_00_7F_00_00;
      8'd125:  cols = 40'h00_41_36_08_00;
      8'd126:  cols = 40'h10_08_08_10_08;
      default: cols = 40'h00_00_00_00_00;
    endcase
    return cols;
  endfunction

endpackage

/* rtl/pfgp_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfgp_store
// Framebuffer byte store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pfgp_store import pfgp_pkg::*; #(
  parameter int DEPTH  = DEF_PANEL_WIDTH * DEF_PAGE_COUNT,
  parameter int ADDR_W = $clog2(DEF_PANEL_WIDTH * DEF_PAGE_COUNT)
) (
  input  logic              clk,
  input  mem_ctl_t          ctl,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered data
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/pfgp_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfgp_ctrl
// Command sequencer: clear sweep, pixel and glyph read-modify-write, byte read.
// ----------------------------------------------------------------------------
module pfgp_ctrl import pfgp_pkg::*; #(
  parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT,
  parameter int PAGE_COUNT   = DEF_PAGE_COUNT,
  parameter int ADDR_W       = $clog2(DEF_PANEL_WIDTH * DEF_PAGE_COUNT)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        op,
  input  logic [7:0]        pos_x,
  input  logic [7:0]        pos_y,
  input  logic              pixel_on,
  input  logic [7:0]        char_code,
  input  logic [9:0]        byte_index,
  output logic              res_valid,
  input  logic              res_stall,
  output logic [7:0]        res_data,
  output mem_ctl_t          mem_ctl,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [7:0]        wr_data,
  output logic [ADDR_W-1:0] rd_addr,
  input  logic [7:0]        rd_data
);

  localparam int STORE_BYTES = PANEL_WIDTH * PAGE_COUNT;

  seq_state_t        state, state_next;
  logic [ADDR_W-1:0] clr_cnt;
  logic [STEP_W-1:0] step;
  logic              cmd_live;
  op_t               op_r;
  logic [7:0]        x_r, y_r;
  logic              on_r;
  logic [39:0]       cols_r;
  logic [9:0]        idx_r;
  logic              wr_pend;
  logic [ADDR_W-1:0] wr_addr_r;
  logic [7:0]        mask_r;
  logic              lit_r;

  logic              accept;
  logic              clr_last, step_last;
  logic [2:0]        step_col;
  logic              step_hi;
  logic [5:0]        col_base;
  logic [7:0]        col_bits;
  logic [15:0]       shifted;
  logic [7:0]        xx;
  logic [4:0]        page;
  logic [7:0]        row_ok;
  logic [7:0]        mask;
  logic [LIN_W-1:0]  lin, idx_lin;
  logic              hit, idx_ok, lit;

  assign accept    = in_valid && !in_stall;
  assign clr_last  = (clr_cnt == ADDR_W'(STORE_BYTES - 1));
  assign step_last = (op_r == OP_GLYPH) ? (step == STEP_W'(GLYPH_STEPS - 1)) : 1'b1;

  // byte of the current step: column and upper or lower page
  assign step_col = step[3:1];
  assign step_hi  = step[0];
  assign col_base = 6'd32 - {step_col, 3'b000};
  assign col_bits = cols_r[col_base +: 8];
  assign shifted  = {8'h00, col_bits} << y_r[2:0];
  assign xx       = x_r + {5'b00000, step_col};
  assign page     = y_r[7:3] + {4'b0000, step_hi};

  // rows of this page that lie on the panel
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      row_ok[b] = ({1'b0, page, 3'(b)} < 9'(PANEL_HEIGHT));
    end
  end

  assign mask    = (step_hi ? shifted[15:8] : shifted[7:0]) & row_ok;
  assign lin     = LIN_W'(xx) + LIN_W'(page) * LIN_W'(PANEL_WIDTH);
  assign hit     = (LIN_W'(xx) < LIN_W'(PANEL_WIDTH)) && (lin < LIN_W'(STORE_BYTES))
                   && (mask != 8'h00) && (op_r != OP_READ);
  assign lit     = (op_r == OP_GLYPH) ? 1'b1 : on_r;
  assign idx_lin = LIN_W'(idx_r);
  assign idx_ok  = (idx_lin < LIN_W'(STORE_BYTES));

  // state register and command latch
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_cnt  <= '0;
      cmd_live <= 1'b0;
      wr_pend  <= 1'b0;
      step     <= '0;
    end else begin
      state   <= state_next;
      wr_pend <= (state == ST_RUN) && hit;
      if (accept) begin
        clr_cnt  <= '0;
        step     <= '0;
        cmd_live <= 1'b1;
      end else begin
        if (state == ST_CLEAR) begin
          clr_cnt <= clr_cnt + 1'b1;
        end
        if (state == ST_RUN) begin
          step <= step + 1'b1;
        end
      end
    end
  end

  // command fields, pending write and result byte
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= op_t'(op);
      x_r      <= pos_x;
      y_r      <= pos_y;
      on_r     <= pixel_on;
      idx_r    <= byte_index;
      cols_r   <= (op_t'(op) == OP_SET) ? SETPIX_COLS : font_columns(char_code);
      res_data <= 8'h00;
    end
    if (state == ST_RUN) begin
      wr_addr_r <= lin[ADDR_W-1:0];
      mask_r    <= mask;
      lit_r     <= lit;
    end
    if (state == ST_FINISH && op_r == OP_READ && idx_ok) begin
      res_data <= rd_data;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_last) begin
          state_next = cmd_live ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = (op_t'(op) == OP_CLEAR) ? ST_CLEAR : ST_RUN;
        end
      end
      ST_RUN: begin
        if (step_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: state_next = ST_DONE;
      ST_DONE: begin
        if (!res_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall      = (state != ST_IDLE);
    res_valid     = (state == ST_DONE);
    mem_ctl.rd_en = (state == ST_RUN);
    rd_addr       = (op_r == OP_READ) ? idx_lin[ADDR_W-1:0] : lin[ADDR_W-1:0];
    mem_ctl.wr_en = 1'b0;
    wr_addr       = wr_addr_r;
    wr_data       = lit_r ? (rd_data | mask_r) : (rd_data & ~mask_r);
    case (state)
      ST_CLEAR: begin
        mem_ctl.wr_en = 1'b1;
        wr_addr       = clr_cnt;
        wr_data       = 8'h00;
      end
      ST_RUN, ST_FINISH: mem_ctl.wr_en = wr_pend;
      default: mem_ctl.wr_en = 1'b0;
    endcase
  end

`ifndef SYNTH
  // a write-back never lands on the byte being read in the same cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(mem_ctl.wr_en && mem_ctl.rd_en && wr_addr == rd_addr))
    else $error("store read and write hit the same byte");

  // an accepted request always leaves idle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != ST_IDLE)
    else $error("request accepted but sequencer idle");

  // only a read request returns a non-zero byte
  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && op_r != OP_READ) |-> res_data == 8'h00)
    else $error("non-zero result for a non-read request");

  // the store is quiet while waiting for or handing over a request
  a_quiet_store: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE || state == ST_DONE) |-> !mem_ctl.wr_en)
    else $error("store written outside a request");
`endif

endmodule

/* rtl/page_framebuffer_glyph_plotter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_framebuffer_glyph_plotter
// Page-organised monochrome framebuffer with pixel set, 5x7 glyph draw,
// full clear and byte read, one result byte per request.
// ----------------------------------------------------------------------------
// Requests run one at a time through a single-port-write, single-port-read
// byte store with a registered read. A draw-character request runs ten
// read-modify-write steps, two pages for each of five glyph columns, with the
// write of one step overlapping the read of the next. Clear sweeps the store
// one byte per cycle; the same sweep runs after reset, during which no request
// is taken. The result sits in an output register, so the next request is
// taken while it waits.
module page_framebuffer_glyph_plotter import pfgp_pkg::*; #(
  parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT,
  parameter int PAGE_COUNT   = DEF_PAGE_COUNT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] op,
  input  logic [7:0] pos_x,
  input  logic [7:0] pos_y,
  input  logic       pixel_on,
  input  logic [7:0] char_code,
  input  logic [9:0] byte_index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_data
);

  localparam int STORE_BYTES = PANEL_WIDTH * PAGE_COUNT;
  localparam int ADDR_W      = $clog2(STORE_BYTES);

  logic              res_valid, res_stall;
  logic [7:0]        res_data;
  mem_ctl_t          mem_ctl;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [7:0]        wr_data, rd_data;

  pfgp_ctrl #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT),
    .PAGE_COUNT   (PAGE_COUNT),
    .ADDR_W       (ADDR_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pixel_on   (pixel_on),
    .char_code  (char_code),
    .byte_index (byte_index),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_data   (res_data),
    .mem_ctl    (mem_ctl),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data)
  );

  pfgp_store #(
    .DEPTH  (STORE_BYTES),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .ctl     (mem_ctl),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // output register: takes a new result whenever it is empty or being drained
  assign res_stall = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && !res_stall) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && !res_stall) begin
      read_data <= res_data;
    end
  end

endmodule

/* bench/tb_page_framebuffer_glyph_plotter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_page_framebuffer_glyph_plotter
// Self-checking bench for the page framebuffer and 5x7 glyph plotter. A
// shadow copy of the frame store predicts the byte returned for every
// request; directed cases cover clipping, coordinate wrap, unprintable codes
// and glyph OR-in, then random traffic runs under four idling patterns.
// ----------------------------------------------------------------------------
module tb_page_framebuffer_glyph_plotter;
  import pfgp_pkg::*;

  localparam int PANEL_W      = DEF_PANEL_WIDTH;
  localparam int PANEL_H      = DEF_PANEL_HEIGHT;
  localparam int PAGES        = DEF_PAGE_COUNT;
  localparam int STORE_BYTES  = PANEL_W * PAGES;
  localparam int FIRST_CODE   = 32;
  localparam int LAST_CODE    = 126;
  localparam int GLYPH_COLS   = 5;
  localparam int GLYPH_ROWS   = 8;
  localparam int IDLE_LIMIT   = 5000;
  localparam int MAX_REPORTS  = 10;
  localparam int DRAIN_CYCLES = 50;

  // 5x7 font, code 32 first, column 0 in the top byte of each entry
  localparam logic [95*40-1:0] FONT_BITS = {
    40'h00_00_00_00_00, 40'h00_00_5F_00_00, 40'h00_07_00_07_00, 40'h14_7F_14_7F_14,
    40'h24_2A_7F_2A_12, 40'h23_13_08_64_62, 40'h36_49_55_22_50, 40'h00_05_03_00_00,
    40'h00_1C_22_41_00, 40'h00_41_22_1C_00, 40'h14_08_3E_08_14, 40'h08_08_3E_08_08,
    40'h00_50_30_00_00, 40'h08_08_08_08_08, 40'h00_60_60_00_00, 40'h20_10_08_04_02,
    40'h3E_51_49_45_3E, 40'h00_42_7F_40_00, 40'h42_61_51_49_46, 40'h21_41_45_4B_31,
    40'h18_14_12_7F_10, 40'h27_45_45_45_39, 40'h3C_4A_49_49_30, 40'h01_71_09_05_03,
    40'h36_49_49_49_36, 40'h06_49_49_29_1E, 40'h00_36_36_00_00, 40'h00_56_36_00_00,
    40'h08_14_22_41_00, 40'h14_14_14_14_14, 40'h00_41_22_14_08, 40'h02_01_51_09_06,
    40'h32_49_79_41_3E, 40'h7E_11_11_11_7E, 40'h7F_49_49_49_36, 40'h3E_41_41_41_22,
    40'h7F_41_41_22_1C, 40'h7F_49_49_49_41, 40'h7F_09_09_09_01, 40'h3E_41_49_49_7A,
    40'h7F_08_08_08_7F, 40'h00_41_7F_41_00, 40'h20_40_41_3F_01, 40'h7F_08_14_22_41,
    40'h7F_40_40_40_40, 40'h7F_02_0C_02_7F, 40'h7F_04_08_10_7F, 40'h3E_41_41_41_3E,
    40'h7F_09_09_09_06, 40'h3E_41_51_21_5E, 40'h7F_09_19_29_46, 40'h46_49_49_49_31,
    40'h01_01_7F_01_01, 40'h3F_40_40_40_3F, 40'h1F_20_40_20_1F, 40'h3F_40_38_40_3F,
    40'h63_14_08_14_63, 40'h07_08_70_08_07, 40'h61_51_49_45_43, 40'h00_7F_41_41_00,
    40'h02_04_08_10_20, 40'h00_41_41_7F_00, 40'h04_02_01_02_04, 40'h40_40_40_40_40,
    40'h00_00_02_05_02, 40'h20_54_54_54_78, 40'h7F_48_44_44_38, 40'h38_44_44_44_20,
    40'h38_44_44_48_7F, 40'h38_54_54_54_18, 40'h08_7E_09_01_02, 40'h0C_52_52_52_3E,
    40'h7F_08_04_04_78, 40'h00_44_7D_40_00, 40'h20_40_44_3D_00, 40'h7F_10_28_44_00,
    40'h00_41_7F_40_00, 40'h7C_04_18_04_78, 40'h7C_08_04_04_78, 40'h38_44_44_44_38,
    40'h7C_14_14_14_08, 40'h08_14_14_18_7C, 40'h7C_08_04_04_08, 40'h48_54_54_54_20,
    40'h04_3F_44_40_20, 40'h3C_40_40_20_7C, 40'h1C_20_40_20_1C, 40'h3C_40_30_40_3C,
    40'h44_28_10_28_44, 40'h0C_50_50_50_3C, 40'h44_64_54_4C_44, 40'h00_08_36_41_00,
    40'h00_00_7F_00_00, 40'h00_41_36_08_00, 40'h10_08_08_10_08
  };

  typedef struct {
    op_t        cmd;
    logic [7:0] data;
  } byte_result_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] op;
  logic [7:0] pos_x;
  logic [7:0] pos_y;
  logic       pixel_on;
  logic [7:0] char_code;
  logic [9:0] byte_index;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] read_data;

  logic [7:0]   shadow_fb [STORE_BYTES];
  byte_result_t pending_results [$];
  int           requests_by_op [4];
  int           results_checked;
  int           mismatches;
  int           idle_cycles;
  int           sender_idle_pct;
  int           recv_stall_pct;
  int           last_x;
  int           last_y;

  page_framebuffer_glyph_plotter uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pixel_on   (pixel_on),
    .char_code  (char_code),
    .byte_index (byte_index),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_data  (read_data)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // one font column, unprintable codes fall back to space
  function automatic logic [7:0] font_column(logic [7:0] code, int col);
    int entry;
    entry = (code < FIRST_CODE || code > LAST_CODE) ? 0 : code - FIRST_CODE;
    return FONT_BITS[(94 - entry) * 40 + (4 - col) * 8 +: 8];
  endfunction

  // set or clear one shadow pixel, clipped to the panel and the store
  function automatic void plot_shadow(int x, int y, logic lit);
    int addr;
    if (x >= PANEL_W || y >= PANEL_H) return;
    addr = x + (y >> 3) * PANEL_W;
    if (addr >= STORE_BYTES) return;
    shadow_fb[addr][y & 7] = lit;
  endfunction

  // run one command on the shadow store and give the byte it returns
  function automatic logic [7:0] apply_to_shadow(op_t cmd, logic [7:0] x, logic [7:0] y,
                                                 logic on, logic [7:0] code, logic [9:0] idx);
    logic [7:0] bits;
    logic [7:0] gx;
    logic [7:0] gy;
    case (cmd)
      OP_CLEAR: begin
        foreach (shadow_fb[a]) shadow_fb[a] = 8'h00;
      end
      OP_SET: begin
        plot_shadow(x, y, on);
      end
      OP_GLYPH: begin
        for (int col = 0; col < GLYPH_COLS; col++) begin
          bits = font_column(code, col);
          for (int row = 0; row < GLYPH_ROWS; row++) begin
            // 8-bit coordinate sums wrap before clipping
            gx = x + 8'(col);
            gy = y + 8'(row);
            if (bits[row]) plot_shadow(gx, gy, 1'b1);
          end
        end
      end
      default: begin
        if (idx < STORE_BYTES) return shadow_fb[idx];
      end
    endcase
    return 8'h00;
  endfunction

  // present one request, hold it until taken, then log its expected byte
  task automatic send_request(op_t cmd, logic [7:0] x, logic [7:0] y, logic on,
                              logic [7:0] code, logic [9:0] idx);
    byte_result_t exp_res;
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    op         <= cmd;
    pos_x      <= x;
    pos_y      <= y;
    pixel_on   <= on;
    char_code  <= code;
    byte_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    exp_res.cmd  = cmd;
    exp_res.data = apply_to_shadow(cmd, x, y, on, code, idx);
    pending_results.push_back(exp_res);
    requests_by_op[cmd]++;
  endtask

  // sender goes quiet until every outstanding result is back
  task automatic wait_results_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // clipping, wrap, unprintable codes and OR-in, checked by read-back
  task automatic test_directed_cases();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    send_request(OP_READ,  8'd0,   8'd0,   1'b0, 8'd0,   10'd0);
    send_request(OP_SET,   8'd0,   8'd0,   1'b1, 8'd0,   10'd0);
    send_request(OP_SET,   8'd127, 8'd63,  1'b1, 8'd0,   10'd0);
    send_request(OP_SET,   8'd128, 8'd5,   1'b1, 8'd0,   10'd0);
    send_request(OP_SET,   8'd3,   8'd64,  1'b1, 8'd0,   10'd0);
    send_request(OP_SET,   8'd255, 8'd255, 1'b1, 8'd0,   10'd0);
    send_request(OP_READ,  8'd0,   8'd0,   1'b0, 8'd0,   10'd0);
    send_request(OP_READ,  8'd0,   8'd0,   1'b0, 8'd0,   10'd1023);
    send_request(OP_SET,   8'd0,   8'd0,   1'b0, 8'd0,   10'd0);
    send_request(OP_READ,  8'd0,   8'd0,   1'b0, 8'd0,   10'd0);
    // glyph hanging off the right and bottom edges
    send_request(OP_GLYPH, 8'd124, 8'd58,  1'b0, 8'd126, 10'd0);
    send_request(OP_READ,  8'd0,   8'd0,   1'b0, 8'd0,   10'd1020);
    send_request(OP_READ,  8'd0,   8'd0,   1'b0, 8'd0,   10'd1023);
    // underscore near 255,255 wraps onto the top-left corner
    send_request(OP_GLYPH, 8'd254, 8'd250, 1'b0, 8'd95,  10'd0);
    send_request(OP_READ,  8'd0,   8'd0,   1'b0, 8'd0,   10'd2);
    // unprintable codes and space leave the store alone
    send_request(OP_GLYPH, 8'd10,  8'd8,   1'b0, 8'd0,   10'd0);
    send_request(OP_GLYPH, 8'd10,  8'd8,   1'b0, 8'd31,  10'd0);
    send_request(OP_GLYPH, 8'd10,  8'd8,   1'b0, 8'd127, 10'd0);
    send_request(OP_GLYPH, 8'd10,  8'd8,   1'b0, 8'd255, 10'd0);
    send_request(OP_GLYPH, 8'd11,  8'd8,   1'b0, 8'd32,  10'd0);
    send_request(OP_READ,  8'd0,   8'd0,   1'b0, 8'd0,   10'd140);
    // bar glyph next to a lit pixel in the same byte must not darken it
    send_request(OP_SET,   8'd20,  8'd0,   1'b1, 8'd0,   10'd0);
    send_request(OP_GLYPH, 8'd18,  8'd1,   1'b0, 8'd124, 10'd0);
    send_request(OP_READ,  8'd0,   8'd0,   1'b0, 8'd0,   10'd20);
    send_request(OP_CLEAR, 8'd0,   8'd0,   1'b0, 8'd0,   10'd0);
    send_request(OP_READ,  8'd0,   8'd0,   1'b0, 8'd0,   10'd20);
  endtask

  // mostly on-panel drawing with read-back near the last draw, some noise
  task automatic random_traffic(int count);
    int         roll;
    op_t        cmd;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] code;
    logic       on;
    logic [9:0] idx;
    for (int n = 0; n < count; n++) begin
      x    = 8'($urandom);
      y    = 8'($urandom);
      code = 8'($urandom);
      on   = 1'($urandom);
      idx  = 10'($urandom);
      roll = $urandom_range(99);
      if (roll < 2) begin
        cmd = OP_CLEAR;
      end else if (roll < 40) begin
        cmd = OP_GLYPH;
        if ($urandom_range(99) < 85) begin
          x    = 8'($urandom_range(PANEL_W - 1));
          y    = 8'($urandom_range(PANEL_H - 1));
          code = 8'($urandom_range(LAST_CODE, FIRST_CODE));
        end
      end else if (roll < 65) begin
        cmd = OP_SET;
        if ($urandom_range(99) < 85) begin
          x = 8'($urandom_range(PANEL_W - 1));
          y = 8'($urandom_range(PANEL_H - 1));
        end
      end else begin
        cmd = OP_READ;
        if ($urandom_range(99) < 70)
          idx = 10'(last_x + $urandom_range(GLYPH_COLS) +
                    ((last_y >> 3) + $urandom_range(1)) * PANEL_W);
      end
      if (cmd == OP_GLYPH || cmd == OP_SET) begin
        last_x = x;
        last_y = y;
      end
      send_request(cmd, x, y, on, code, idx);
    end
  endtask

  task automatic test_steady_flow();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    random_traffic(456);
  endtask

  task automatic test_sender_gaps();
    sender_idle_pct = 58;
    recv_stall_pct  = 0;
    random_traffic(456);
  endtask

  task automatic test_receiver_stalls();
    sender_idle_pct = 0;
    recv_stall_pct  = 58;
    random_traffic(456);
  endtask

  // light idling on both sides, with one full drain half way
  task automatic test_both_idle();
    sender_idle_pct = 12;
    recv_stall_pct  = 12;
    random_traffic(228);
    wait_results_drained();
    random_traffic(228);
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    out_stall <= (!rst && $urandom_range(99) < recv_stall_pct);
  end

  function automatic void note_mismatch(string what, logic [7:0] want, logic [7:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch %s at %0t: expected %02h got %02h", what, $realtime, want, got);
  endfunction

  // compare each returned byte with the oldest prediction
  always @(posedge clk) begin
    byte_result_t exp_res;
    if (!rst && out_valid && !out_stall) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        note_mismatch("unrequested result", 8'hxx, read_data);
      end else begin
        exp_res = pending_results.pop_front();
        if (read_data !== exp_res.data) note_mismatch(exp_res.cmd.name(), exp_res.data,
                                                      read_data);
      end
    end
  end

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst             = 1'b1;
    in_valid        = 1'b0;
    op              = OP_CLEAR;
    pos_x           = 8'd0;
    pos_y           = 8'd0;
    pixel_on        = 1'b0;
    char_code       = 8'd0;
    byte_index      = 10'd0;
    out_stall       = 1'b0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    results_checked = 0;
    mismatches      = 0;
    idle_cycles     = 0;
    last_x          = 0;
    last_y          = 0;
    foreach (requests_by_op[i]) requests_by_op[i] = 0;
    foreach (shadow_fb[a]) shadow_fb[a] = 8'h00;

    // synchronous reset
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_steady_flow();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests: %0d clear, %0d set pixel, %0d glyph, %0d read",
             requests_by_op[OP_CLEAR] + requests_by_op[OP_SET] + requests_by_op[OP_GLYPH] +
             requests_by_op[OP_READ], requests_by_op[OP_CLEAR], requests_by_op[OP_SET],
             requests_by_op[OP_GLYPH], requests_by_op[OP_READ]);
    $display("%0d results checked over four idling patterns, %0d mismatches, %0d left over",
             results_checked, mismatches, pending_results.size());
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
